[sv/sha1md_pkg.sv]
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round helpers for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  typedef logic [31:0] word_t;

  localparam int NUM_H     = 5;
  localparam int WIN_DEPTH = 16;

  localparam word_t H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;

  // Control from the sequencer to the message schedule window.
  typedef struct packed {
    logic  shift;  // advance the window by one word
    logic  ext;    // take the new word from the sequencer, not the expansion
    word_t word;   // word supplied by the sequencer
  } sched_ctl_t;

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K_R0;
    end else if (rnd < 7'd40) begin
      k = K_R1;
    end else if (rnd < 7'd60) begin
      k = K_R2;
    end else begin
      k = K_R3;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

[sv/sha1md_if.sv]
// ----------------------------------------------------------------------------
// sha1md channel interfaces
// Valid/ready channels for message input and digest output.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[sv/sha1_message_digest.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 hash of a byte stream, at most one byte per input beat, digest as five words.
// ----------------------------------------------------------------------------
// Bytes are packed big-endian into a sixteen-word schedule window. A byte
// that does not close a 64-byte block or end the message leaves the input
// ready. A byte that closes a block holds the input off while the single
// round unit runs all 80 rounds and the result is folded into the chaining
// values. The end of a message pads the last block word by word (one word
// per cycle), runs one or two compressions and then offers h0..h4 as five
// output beats, the last one flagged; the next message starts from the
// initial chaining values.
// ----------------------------------------------------------------------------
module sha1_message_digest import sha1md_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sha1md_in_if.sink     in_ch,
  sha1md_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_LENLO = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] RET_BYTE = 2'd0;
  localparam logic [1:0] RET_FILL = 2'd1;
  localparam logic [1:0] RET_OUT  = 2'd2;

  localparam logic [2:0] LAST_IDX = 3'd4;

  logic [2:0]  state_r,    state_nxt;
  logic [1:0]  ret_r,      ret_nxt;
  logic        eom_pend_r, eom_pend_nxt;
  logic [5:0]  byte_cnt_r, byte_cnt_nxt;
  logic [3:0]  wc_r,       wc_nxt;
  logic [23:0] acc_r,      acc_nxt;
  logic [63:0] bitlen_r,   bitlen_nxt;
  logic [6:0]  rnd_r,      rnd_nxt;
  logic [2:0]  oidx_r,     oidx_nxt;
  word_t       chain_r   [NUM_H];
  word_t       chain_nxt [NUM_H];

  word_t       vars [NUM_H];
  word_t       w_head;
  word_t       pad_word;
  sched_ctl_t  sched_ctl;
  logic        rnd_load;
  logic        rnd_step;
  logic        in_beat;
  logic        out_beat;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  // Held bytes of the open word, then the 0x80 marker, then zeros.
  always_comb begin
    case (byte_cnt_r[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h000000};
      2'd1:    pad_word = {acc_r[7:0], PAD_BYTE, 16'h0000};
      2'd2:    pad_word = {acc_r[15:0], PAD_BYTE, 8'h00};
      2'd3:    pad_word = {acc_r[23:0], PAD_BYTE};
      default: pad_word = {PAD_BYTE, 24'h000000};
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    eom_pend_nxt = eom_pend_r;
    byte_cnt_nxt = byte_cnt_r;
    wc_nxt       = wc_r;
    acc_nxt      = acc_r;
    bitlen_nxt   = bitlen_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    chain_nxt    = chain_r;
    sched_ctl    = '0;
    rnd_load     = 1'b0;
    rnd_step     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.has_byte) begin
            acc_nxt      = {acc_r[15:0], in_ch.data_byte};
            byte_cnt_nxt = byte_cnt_r + 6'd1;
            bitlen_nxt   = bitlen_r + 64'd8;
            if (byte_cnt_r[1:0] == 2'd3) begin
              sched_ctl.shift = 1'b1;
              sched_ctl.ext   = 1'b1;
              sched_ctl.word  = {acc_r, in_ch.data_byte};
            end
          end
          if (in_ch.has_byte && byte_cnt_r == 6'd63) begin
            rnd_load     = 1'b1;
            ret_nxt      = RET_BYTE;
            eom_pend_nxt = in_ch.end_of_message;
            state_nxt    = S_ROUND;
          end else if (in_ch.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        sched_ctl.shift = 1'b1;
        sched_ctl.ext   = 1'b1;
        sched_ctl.word  = pad_word;
        wc_nxt          = byte_cnt_r[5:2] + 4'd1;
        if (byte_cnt_r[5:2] == 4'd15) begin
          // The marker filled the block; the length goes into a second one.
          rnd_load  = 1'b1;
          ret_nxt   = RET_FILL;
          state_nxt = S_ROUND;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        sched_ctl.shift = 1'b1;
        sched_ctl.ext   = 1'b1;
        wc_nxt          = wc_r + 4'd1;
        if (wc_r == 4'd14) begin
          sched_ctl.word = bitlen_r[63:32];
          state_nxt      = S_LENLO;
        end else begin
          sched_ctl.word = '0;
          if (wc_r == 4'd15) begin
            rnd_load  = 1'b1;
            ret_nxt   = RET_FILL;
            state_nxt = S_ROUND;
          end
        end
      end
      S_LENLO: begin
        sched_ctl.shift = 1'b1;
        sched_ctl.ext   = 1'b1;
        sched_ctl.word  = bitlen_r[31:0];
        wc_nxt          = 4'd0;
        rnd_load        = 1'b1;
        ret_nxt         = RET_OUT;
        state_nxt       = S_ROUND;
      end
      S_ROUND: begin
        rnd_step        = 1'b1;
        sched_ctl.shift = 1'b1;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = S_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_ADD: begin
        for (int k = 0; k < NUM_H; k++) begin
          chain_nxt[k] = chain_r[k] + vars[k];
        end
        case (ret_r)
          RET_OUT: begin
            oidx_nxt  = '0;
            state_nxt = S_OUT;
          end
          RET_FILL: begin
            state_nxt = S_FILL;
          end
          default: begin
            if (eom_pend_r) begin
              eom_pend_nxt = 1'b0;
              state_nxt    = S_PAD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_beat) begin
          if (oidx_r == LAST_IDX) begin
            oidx_nxt     = '0;
            chain_nxt    = H_INIT;
            bitlen_nxt   = '0;
            byte_cnt_nxt = '0;
            state_nxt    = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= RET_BYTE;
      eom_pend_r <= 1'b0;
      byte_cnt_r <= '0;
      wc_r       <= '0;
      bitlen_r   <= '0;
      rnd_r      <= '0;
      oidx_r     <= '0;
      chain_r    <= H_INIT;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      eom_pend_r <= eom_pend_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      wc_r       <= wc_nxt;
      bitlen_r   <= bitlen_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  sha1md_sched u_sched (
    .clk    (clk),
    .ctl    (sched_ctl),
    .w_head (w_head)
  );

  sha1md_round u_round (
    .clk   (clk),
    .load  (rnd_load),
    .step  (rnd_step),
    .rnd   (rnd_r),
    .wi    (w_head),
    .chain (chain_r),
    .vars  (vars)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = chain_r[oidx_r];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == LAST_IDX);

endmodule

[sv/sha1md_sched.sv]
// ----------------------------------------------------------------------------
// sha1md_sched
// Sixteen-word message schedule window, kept as a shift line.
// ----------------------------------------------------------------------------
module sha1md_sched import sha1md_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_head
);

  word_t win_r [WIN_DEPTH];
  word_t mix;
  word_t expand;

  // With the window holding W[i..i+15], this is W[i+16].
  assign mix    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign expand = {mix[30:0], mix[31]};
  assign w_head = win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WIN_DEPTH-1] <= ctl.ext ? ctl.word : expand;
    end
  end

endmodule

[sv/sha1md_round.sv]
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round per cycle while step is high, on the working variables a..e.
// ----------------------------------------------------------------------------
module sha1md_round import sha1md_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  logic       step,
  input  logic [6:0] rnd,
  input  word_t      wi,
  input  word_t      chain [NUM_H],
  output word_t      vars  [NUM_H]
);

  word_t a_r, b_r, c_r, d_r, e_r;
  word_t t;

  assign t = {a_r[26:0], a_r[31:27]} + round_f(rnd, b_r, c_r, d_r) + e_r
             + round_k(rnd) + wi;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= chain[0];
      b_r <= chain[1];
      c_r <= chain[2];
      d_r <= chain[3];
      e_r <= chain[4];
    end else if (step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign vars[0] = a_r;
  assign vars[1] = b_r;
  assign vars[2] = c_r;
  assign vars[3] = d_r;
  assign vars[4] = e_r;

endmodule

[sv/sha1md_checker.sv]
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks for the SHA-1 digest block, bound to the top level.
// ----------------------------------------------------------------------------
module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Input is never taken while digest words are still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words pending");

  // The last flag rides on the fifth word only.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last flag does not match word index");

  // A non-final beat is followed by the next word at once.
  a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not in sequence");

  // After the final beat the block takes the next message.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && !out_valid))
    else $error("block not ready after the digest");

  // A stalled digest word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha1_message_digest. Byte streams go in on the
// input channel; a built-in SHA-1 digest predictor computes the five words
// each message must produce, and every output beat is compared against them
// in order. Both channels idle at random, and one long output hold-off keeps
// the block on its digest words so that it stalls its input.
// ----------------------------------------------------------------------------
module tb import sha1md_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_TARGET  = 310;

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  // Tracks the message in flight and the digest words still owed by the block.
  class digest_scoreboard;
    word_t          chain[NUM_H];
    logic [7:0]     block_bytes[64];
    int             fill;
    logic [63:0]    bit_len;
    digest_beat_t   pending_words[$];
    int             errors;

    function new();
      errors = 0;
      start_message();
    endfunction

    function void start_message();
      chain = H_INIT;
      fill = 0;
      bit_len = '0;
    endfunction

    function void compress_block();
      word_t w[16];
      word_t a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++) begin
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                block_bytes[4*i+3]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (i = 0; i < 80; i++) begin
        // The sixteen-word window is expanded in place once past round 15.
        if (i >= 16) begin
          t = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
          w[i % 16] = {t[30:0], t[31]};
        end
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K_R0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i % 16];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void note_input(logic [7:0] data, logic has, logic eom);
      digest_beat_t beat;
      int i;
      if (has) begin
        block_bytes[fill] = data;
        bit_len += 64'd8;
        fill++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
      end
      if (!eom) return;
      block_bytes[fill] = PAD_BYTE;
      for (i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room left for the length field, so it goes into an extra block.
      if (fill >= 56) begin
        compress_block();
        for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (i = 0; i < NUM_H; i++) begin
        beat.word = chain[i];
        beat.index = 3'(i);
        beat.last = (i == NUM_H - 1);
        pending_words.push_back(beat);
      end
      start_message();
    endfunction

    function void check_digest_word(word_t word, logic [2:0] index, logic last);
      digest_beat_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d", word, index);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (word !== want.word) begin
        $error("digest_word: expected %h, actual %h", want.word, word);
        errors++;
      end
      if (index !== want.index) begin
        $error("word_index: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_word: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digest_scoreboard sb = new();

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int cycle_count;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.has_byte <= has;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (has || eom) items_sent++;
  endtask

  // A message of len bytes with idle beats sprinkled in. The end is flagged
  // either on the last byte or on a separate beat that carries no byte.
  task automatic send_message(input int len, input int idle_pct);
    bit split_end;
    int i;
    split_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < idle_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int r;
    int boundary[6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 12);
    if (r < 92) return boundary[$urandom_range(0, 5)];
    return $urandom_range(100, 130);
  endfunction

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      sb.note_input(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message);
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_digest_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
    end
  end

  // Output side: random ready, plus one long hold-off on request.
  initial begin
    int held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.has_byte <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty messages, ignored bytes, extreme single bytes, "abc", a split end and a two-byte message.
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);

    // Random messages in three idling phases; the last opens with a hold-off.
    src_idle_pct = 18;
    sink_idle_pct = 77;
    while (items_sent < ITEM_TARGET / 3) send_message(pick_length(), 8);
    src_idle_pct = 77;
    sink_idle_pct = 18;
    while (items_sent < 2 * ITEM_TARGET / 3) send_message(pick_length(), 8);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 1'b1;
    repeat (6) send_message($urandom_range(0, 3), 0);
    while (items_sent < ITEM_TARGET) send_message(pick_length(), 8);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_words.size() != 0) begin
      $error("%0d digest words never arrived", sb.pending_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/sha1md_pkg.sv
sv/sha1md_if.sv
sv/sha1md_sched.sv
sv/sha1md_round.sv
sv/sha1_message_digest.sv
sv/sha1md_checker.sv
tb/tb.sv
